[src/vector_distance_multi_metric_macros.svh]
// assertion helpers used by the checker file
`ifndef VECTOR_DISTANCE_MULTI_METRIC_MACROS_SVH
`define VECTOR_DISTANCE_MULTI_METRIC_MACROS_SVH

// checked only outside reset
`define VDMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define VDMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/vdmm_pkg.sv]
`timescale 1ns / 1ps
package vdmm_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned AccW  = 64;
  localparam int unsigned MetW  = 3;

  localparam logic [AccW-1:0] CosScale = 64'd1000000;
  localparam logic [AccW-1:0] AllOnes  = '1;

  // metric codes
  localparam logic [MetW-1:0] MetEuc = 3'd0;
  localparam logic [MetW-1:0] MetCos = 3'd1;
  localparam logic [MetW-1:0] MetDot = 3'd2;
  localparam logic [MetW-1:0] MetMan = 3'd3;

  typedef struct packed {
    logic signed [ElemW-1:0] elem_a;
    logic signed [ElemW-1:0] elem_b;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [AccW-1:0] distance;
    logic            divisor_zero;
  } out_item_t;

  typedef enum logic [2:0] {
    MS_NORM_LL,
    MS_NORM_HL,
    MS_NORM_LH,
    MS_DOT_L,
    MS_DOT_H
  } mul_sel_e;

  typedef enum logic {
    DS_DEN,
    DS_QUO
  } div_sel_e;

  typedef enum logic [1:0] {
    RS_PLAIN,
    RS_SCALE,
    RS_SCALE_FLAG,
    RS_COS
  } res_sel_e;

  typedef struct packed {
    logic     capture;
    logic     acc_en;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     den_load;
    logic     load_out;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic cos_sel;
    logic norm_zero;
    logic den_zero;
    logic div_busy;
  } dp_status_t;

endpackage

[src/vdmm_div.sv]
`timescale 1ns / 1ps
module vdmm_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [vdmm_pkg::AccW-1:0] dividend_i,
  input  logic [vdmm_pkg::AccW-1:0] divisor_i,
  output logic                   busy_o,
  output logic [vdmm_pkg::AccW-1:0] quotient_o
);
  import vdmm_pkg::*;

  localparam int unsigned CntW = $clog2(AccW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0] rem_q, rem_d;
  logic [AccW-1:0] quo_q, quo_d;
  logic [AccW-1:0] dvs_q, dvs_d;
  logic [AccW:0]   shifted;
  logic [AccW:0]   trial;

  // one quotient bit a cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[AccW-1]};
    trial   = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(AccW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[AccW]) begin
        rem_d = trial[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = shifted[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[src/vdmm_dp.sv]
`timescale 1ns / 1ps
module vdmm_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vdmm_pkg::MetW-1:0]   cfg_wdata_i,
  input  vdmm_pkg::in_item_t          in_data_i,
  input  vdmm_pkg::dp_cmd_t           cmd_i,
  output vdmm_pkg::dp_status_t        status_o,
  output vdmm_pkg::out_item_t         out_data_o
);
  import vdmm_pkg::*;

  // scale-down by 1000000: long division in 12-bit digits, each digit by
  // reciprocal multiply in one phase and back-multiply in the next
  localparam int unsigned      DigW     = 12;
  localparam int unsigned      DigN     = 6;
  localparam int unsigned      RemW     = 20;
  localparam int unsigned      ScCntW   = 3;
  localparam int unsigned      RecipSh  = 50;
  localparam logic [ElemW-1:0] RecipMul = 32'd1125899907;
  localparam logic [ElemW-1:0] Scale32  = CosScale[ElemW-1:0];

  logic [MetW-1:0] metric_q;
  logic [MetW-1:0] m1_q;

  // element stage products
  logic signed [ElemW:0]     diff;
  logic signed [2*ElemW+1:0] diff_sq;
  logic        [ElemW:0]     diff_abs;
  logic signed [AccW-1:0]    prod_ab, prod_aa, prod_bb;
  logic        [AccW-1:0]    term;
  logic [AccW-1:0] term_q, ab_q, aa_q, bb_q;

  // accumulators
  logic [AccW-1:0] sum_q, dot_q, na_q, nb_q;

  // cosine work registers
  logic [ElemW-1:0] mul_a, mul_b;
  logic [AccW-1:0]  mul_p;
  logic [AccW-1:0]  wk_q, wk_d;
  logic [AccW-1:0]  den_q;
  logic [AccW-1:0]  div_dividend, div_quo;
  logic             div_busy;
  logic             div_start;
  logic [AccW-1:0]  quo_signed;

  // scale-down unit
  logic                 sc_start;
  logic                 sc_busy_q, sc_busy_d;
  logic                 sc_ph_q, sc_ph_d;
  logic [ScCntW-1:0]    sc_cnt_q, sc_cnt_d;
  logic [DigN*DigW-1:0] sc_dvd_q, sc_dvd_d;
  logic [RemW-1:0]      sc_rem_q, sc_rem_d;
  logic [DigW-1:0]      sc_qd_q, sc_qd_d;
  logic [AccW-1:0]      sc_quo_q, sc_quo_d;
  logic [ElemW-1:0]     sc_v;
  logic [AccW-1:0]      sc_prod;
  logic [ElemW-1:0]     sc_back;

  out_item_t out_q, out_d;

  always_comb begin
    diff     = $signed({in_data_i.elem_a[ElemW-1], in_data_i.elem_a})
             - $signed({in_data_i.elem_b[ElemW-1], in_data_i.elem_b});
    diff_sq  = diff * diff;
    diff_abs = diff[ElemW] ? (~diff + 1'b1) : diff;
    prod_ab  = in_data_i.elem_a * in_data_i.elem_b;
    prod_aa  = in_data_i.elem_a * in_data_i.elem_a;
    prod_bb  = in_data_i.elem_b * in_data_i.elem_b;
    case (metric_q)
      MetEuc:  term = diff_sq[AccW-1:0];
      MetMan:  term = AccW'(diff_abs);
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= MetEuc;
    end else if (cfg_we_i) begin
      metric_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      term_q <= term;
      ab_q   <= prod_ab;
      aa_q   <= prod_aa;
      bb_q   <= prod_bb;
      m1_q   <= metric_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (cmd_i.load_out) begin
      sum_q <= '0;
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (cmd_i.acc_en) begin
      sum_q <= sum_q + term_q;
      dot_q <= dot_q + ab_q;
      na_q  <= na_q + aa_q;
      nb_q  <= nb_q + bb_q;
    end
  end

  // shared 32x32 multiplier, low 64 bits of a wide product built in steps
  always_comb begin
    case (cmd_i.mul_sel)
      MS_NORM_LL: begin
        mul_a = na_q[ElemW-1:0];
        mul_b = nb_q[ElemW-1:0];
      end
      MS_NORM_HL: begin
        mul_a = na_q[AccW-1:ElemW];
        mul_b = nb_q[ElemW-1:0];
      end
      MS_NORM_LH: begin
        mul_a = na_q[ElemW-1:0];
        mul_b = nb_q[AccW-1:ElemW];
      end
      MS_DOT_L: begin
        mul_a = dot_q[ElemW-1:0];
        mul_b = CosScale[ElemW-1:0];
      end
      MS_DOT_H: begin
        mul_a = dot_q[AccW-1:ElemW];
        mul_b = CosScale[ElemW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = AccW'(mul_a) * AccW'(mul_b);
    wk_d  = wk_q;
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_sel inside {MS_NORM_LL, MS_DOT_L}) begin
        wk_d = mul_p;
      end else begin
        wk_d = wk_q + {mul_p[ElemW-1:0], {ElemW{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q <= wk_d;
    if (cmd_i.den_load) begin
      den_q <= sc_quo_q;
    end
  end

  // digit quotient is below 4096 as the running remainder stays under the scale
  always_comb begin
    sc_v      = {sc_rem_q, sc_dvd_q[DigN*DigW-1 -: DigW]};
    sc_prod   = AccW'(sc_v) * AccW'(RecipMul);
    sc_back   = sc_v - ElemW'(sc_qd_q) * Scale32;
    sc_busy_d = sc_busy_q;
    sc_ph_d   = sc_ph_q;
    sc_cnt_d  = sc_cnt_q;
    sc_dvd_d  = sc_dvd_q;
    sc_rem_d  = sc_rem_q;
    sc_qd_d   = sc_qd_q;
    sc_quo_d  = sc_quo_q;
    if (sc_start) begin
      sc_busy_d = 1'b1;
      sc_ph_d   = 1'b0;
      sc_cnt_d  = ScCntW'(DigN);
      sc_dvd_d  = {{(DigN*DigW-AccW){1'b0}}, wk_q};
      sc_rem_d  = '0;
      sc_quo_d  = '0;
    end else if (sc_busy_q) begin
      if (!sc_ph_q) begin
        sc_qd_d = sc_prod[RecipSh +: DigW];
        sc_ph_d = 1'b1;
      end else begin
        sc_rem_d  = sc_back[RemW-1:0];
        sc_quo_d  = {sc_quo_q[AccW-DigW-1:0], sc_qd_q};
        sc_dvd_d  = {sc_dvd_q[DigN*DigW-DigW-1:0], {DigW{1'b0}}};
        sc_cnt_d  = sc_cnt_q - 1'b1;
        sc_busy_d = (sc_cnt_q != ScCntW'(1));
        sc_ph_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_busy_q <= 1'b0;
      sc_ph_q   <= 1'b0;
      sc_cnt_q  <= '0;
    end else begin
      sc_busy_q <= sc_busy_d;
      sc_ph_q   <= sc_ph_d;
      sc_cnt_q  <= sc_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_dvd_q <= sc_dvd_d;
    sc_rem_q <= sc_rem_d;
    sc_qd_q  <= sc_qd_d;
    sc_quo_q <= sc_quo_d;
  end

  always_comb begin
    div_dividend = wk_q[AccW-1] ? (~wk_q + 1'b1) : wk_q;
    div_start    = cmd_i.div_start && (cmd_i.div_sel == DS_QUO);
    sc_start     = cmd_i.div_start && (cmd_i.div_sel == DS_DEN);
  end

  vdmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (den_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // wk still holds the scaled dot product, its sign sets the quotient sign
  always_comb begin
    quo_signed = wk_q[AccW-1] ? (~div_quo + 1'b1) : div_quo;
    out_d      = out_q;
    if (cmd_i.load_out) begin
      out_d.divisor_zero = 1'b0;
      case (cmd_i.res_sel)
        RS_PLAIN: begin
          case (m1_q)
            MetEuc, MetMan: out_d.distance = sum_q;
            MetDot:         out_d.distance = ~dot_q;
            default:        out_d.distance = AllOnes;
          endcase
        end
        RS_SCALE: out_d.distance = CosScale;
        RS_SCALE_FLAG: begin
          out_d.distance     = CosScale;
          out_d.divisor_zero = 1'b1;
        end
        RS_COS:  out_d.distance = CosScale - quo_signed;
        default: out_d.distance = AllOnes;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o.cos_sel   = (m1_q == MetCos);
  assign status_o.norm_zero = (na_q == '0) || (nb_q == '0);
  assign status_o.den_zero  = (den_q == '0);
  assign status_o.div_busy  = div_busy || sc_busy_q;
  assign out_data_o         = out_q;

endmodule

[src/vdmm_ctrl.sv]
`timescale 1ns / 1ps
module vdmm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  vdmm_pkg::dp_status_t  status_i,
  output vdmm_pkg::dp_cmd_t     cmd_o
);
  import vdmm_pkg::*;

  typedef enum logic [3:0] {
    S_RUN,
    S_EVAL,
    S_N0,
    S_N1,
    S_N2,
    S_DEN,
    S_DENW,
    S_DCHK,
    S_D0,
    S_D1,
    S_QUO,
    S_QUOW,
    S_OUT
  } state_e;

  state_e   state_q, state_d;
  logic     p1_valid_q, p1_valid_d;
  logic     p1_last_q, p1_last_d;
  logic     out_valid_q, out_valid_d;
  res_sel_e res_sel_q, res_sel_d;
  logic     in_ready;
  dp_cmd_t  cmd;

  always_comb begin
    state_d     = state_q;
    res_sel_d   = res_sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    cmd.mul_sel = MS_NORM_LL;
    cmd.div_sel = DS_DEN;
    cmd.res_sel = res_sel_q;
    // hold off new words while a closing word is still in the element stage
    in_ready    = (state_q == S_RUN) && !(p1_valid_q && p1_last_q);
    cmd.capture = in_valid_i && in_ready;
    p1_valid_d  = cmd.capture;
    p1_last_d   = cmd.capture ? in_last_i : p1_last_q;

    case (state_q)
      S_RUN: begin
        cmd.acc_en = p1_valid_q;
        if (p1_valid_q && p1_last_q) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status_i.cos_sel) begin
          res_sel_d = RS_PLAIN;
          state_d   = S_OUT;
        end else if (status_i.norm_zero) begin
          res_sel_d = RS_SCALE;
          state_d   = S_OUT;
        end else begin
          state_d = S_N0;
        end
      end
      S_N0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_NORM_LL;
        state_d     = S_N1;
      end
      S_N1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_NORM_HL;
        state_d     = S_N2;
      end
      S_N2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_NORM_LH;
        state_d     = S_DEN;
      end
      S_DEN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_DEN;
        state_d       = S_DENW;
      end
      S_DENW: begin
        if (!status_i.div_busy) begin
          cmd.den_load = 1'b1;
          state_d      = S_DCHK;
        end
      end
      S_DCHK: begin
        if (status_i.den_zero) begin
          res_sel_d = RS_SCALE_FLAG;
          state_d   = S_OUT;
        end else begin
          state_d = S_D0;
        end
      end
      S_D0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DOT_L;
        state_d     = S_D1;
      end
      S_D1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DOT_H;
        state_d     = S_QUO;
      end
      S_QUO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_QUO;
        state_d       = S_QUOW;
      end
      S_QUOW: begin
        cmd.div_sel = DS_QUO;
        if (!status_i.div_busy) begin
          res_sel_d = RS_COS;
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      p1_valid_q  <= 1'b0;
      p1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      res_sel_q   <= RS_PLAIN;
    end else begin
      state_q     <= state_d;
      p1_valid_q  <= p1_valid_d;
      p1_last_q   <= p1_last_d;
      out_valid_q <= out_valid_d;
      res_sel_q   <= res_sel_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[src/vector_distance_multi_metric.sv]
`timescale 1ns / 1ps
// non-closing words are taken one a cycle; the closing word of a vector blocks input until done
// euclidean, manhattan, dot, unknown metrics and cosine with a zero norm: sum, evaluate, output
// cosine: norm product, scale-down, zero-divisor check, scaled dot, then the radix-2 divide
// a finished result waits in the output register while the next vector streams in
// rst_ni is asynchronous, active low: clears metric to squared euclidean and all sums to zero
module vector_distance_multi_metric (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vdmm_pkg::MetW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  vdmm_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vdmm_pkg::out_item_t           out_data_o
);
  import vdmm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  vdmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_element),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vdmm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

[src/vdmm_checker.sv]
`timescale 1ns / 1ps
`include "vector_distance_multi_metric_macros.svh"
module vdmm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [vdmm_pkg::MetW-1:0]     cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input vdmm_pkg::in_item_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input vdmm_pkg::out_item_t           out_data_o
);
  import vdmm_pkg::*;

  `VDMM_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result word changed while stalled")
  `VDMM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")
  `VDMM_ASSERT(a_flag_value, out_valid_o && out_data_o.divisor_zero |-> out_data_o.distance == CosScale, "zero divisor flag without scale value")
  `VDMM_ASSERT(a_last_blocks, in_valid_i && in_ready_o && in_data_i.last_element |=> !in_ready_o, "input taken right after a closing word")

endmodule

bind vector_distance_multi_metric vdmm_checker u_vdmm_checker (.*);
